/* hdl/acfm_pkg.sv */
// shared types and constants for the aho-corasick first match unit
`default_nettype none

package acfm_pkg;

    localparam int NodeCountDefault   = 1024;
    localparam int OffsetWidthDefault = 32;
    localparam int IdWidth            = 10;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_NODE  = 2'd1,
        OP_ROOT  = 2'd2,
        OP_TEXT  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  entry_index;
        logic [15:0] term_code;
        logic [7:0]  node_depth;
        logic [7:0]  child_count;
        logic [9:0]  first_child;
        logic [9:0]  fail_node;
        logic [7:0]  in_label;
        logic [7:0]  root_target;
        logic [7:0]  text_byte;
        logic        text_last;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] first_offset;
        logic [31:0] last_offset;
        logic [15:0] pattern_index;
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic cap;        // capture request fields
        logic rd_cur;     // read node store at current node
        logic rd_child;   // read node store at child candidate
        logic rd_root;    // read root table at byte
        logic init_scan;  // set up child scan from current node entry
        logic next_child; // step child index
        logic take_child; // current := child candidate, consume byte
        logic take_root;  // current := root target, consume byte
        logic take_fail;  // current := fail link
        logic go_root;    // current := 0
        logic restart;    // start search
        logic set_done;
        logic emit_hit;
        logic emit_miss;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       last;
        logic       done;
        logic       cur_root;
        logic       scan_end;
        logic       label_eq;
        logic       fail_zero;
        logic       fail_cap;
        logic       term_nz;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/acfm_datapath.sv */
// datapath: node and root stores, current node, offset and result register
`default_nettype none

module acfm_datapath #(
    parameter int NODE_COUNT   = acfm_pkg::NodeCountDefault,
    parameter int OFFSET_WIDTH = acfm_pkg::OffsetWidthDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire acfm_pkg::req_t req,
    input  wire acfm_pkg::cmd_t cmd,
    output acfm_pkg::stat_t     stat,
    output acfm_pkg::res_t      res,
    output logic                res_valid
);
    import acfm_pkg::*;

    // node ids are 10 bits wide, so no more than 1024 entries are reachable
    localparam int MemDepth = (NODE_COUNT > 1024) ? 1024 : NODE_COUNT;
    localparam int AW = $clog2(MemDepth);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam logic [FW-1:0] FailMax = FW'(NODE_COUNT);

    // node memory word: term, depth, count, child, fail, label
    typedef struct packed {
        logic [15:0] term;
        logic [7:0]  depth;
        logic [7:0]  count;
        logic [9:0]  child;
        logic [9:0]  fail;
        logic [7:0]  label;
    } node_t;

    node_t node_mem [MemDepth];
    logic [7:0] root_mem [256];

    req_t  req_reg;
    node_t rd_reg;
    logic  rd_ok_reg;
    logic [7:0] root_rd_reg;
    logic [9:0] cur_reg;
    logic [OFFSET_WIDTH-1:0] ofs_reg;
    logic done_reg;
    logic [9:0] base_reg;
    logic [7:0] cnt_reg;
    logic [7:0] k_reg;
    logic [9:0] cand_reg;
    logic [FW-1:0] fails_reg;
    res_t res_reg;
    logic valid_reg;

    node_t rd_eff;
    logic [9:0] rd_addr;
    logic [9:0] cand;

    assign cand   = base_reg + 10'(k_reg);
    assign rd_eff = rd_ok_reg ? rd_reg : '0;

    // address of the node store read
    always_comb
    begin
        rd_addr = cmd.rd_child ? cand : cur_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.cap && req.op == OP_NODE && 32'(req.entry_index) < NODE_COUNT)
        begin
            node_mem[AW'(req.entry_index)] <= '{req.term_code, req.node_depth,
                req.child_count, req.first_child, req.fail_node, req.in_label};
        end
        if (cmd.cap && req.op == OP_ROOT && req.entry_index[9:8] == 2'b00)
        begin
            root_mem[req.entry_index[7:0]] <= req.root_target;
        end
        if (cmd.rd_cur || cmd.rd_child)
        begin
            rd_reg <= node_mem[AW'(rd_addr)];
        end
        if (cmd.rd_root)
        begin
            root_rd_reg <= root_mem[req_reg.text_byte];
        end
        if (cmd.cap)
        begin
            req_reg <= req;
        end
        if (cmd.rd_child)
        begin
            cand_reg <= cand;
        end
        if (cmd.init_scan)
        begin
            base_reg <= rd_eff.child;
            cnt_reg  <= rd_eff.count;
        end
        if (cmd.emit_hit)
        begin
            res_reg.found         <= 1'b1;
            res_reg.first_offset  <= 32'(ofs_reg - OFFSET_WIDTH'(rd_eff.depth));
            res_reg.last_offset   <= 32'(ofs_reg - OFFSET_WIDTH'(1));
            res_reg.pattern_index <= rd_eff.term - 16'd1;
        end
        else if (cmd.emit_miss)
        begin
            res_reg <= '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            ofs_reg   <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            k_reg     <= '0;
            fails_reg <= '0;
        end
        else
        begin
            valid_reg <= cmd.emit_hit || cmd.emit_miss;
            if (cmd.rd_cur || cmd.rd_child)
            begin
                rd_ok_reg <= 32'(rd_addr) < NODE_COUNT;
            end
            if (cmd.cap)
            begin
                fails_reg <= '0;
            end
            if (cmd.init_scan)
            begin
                k_reg <= '0;
            end
            else if (cmd.next_child)
            begin
                k_reg <= k_reg + 8'd1;
            end
            if (cmd.restart)
            begin
                cur_reg  <= '0;
                ofs_reg  <= '0;
                done_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_done)
                begin
                    done_reg <= 1'b1;
                end
                if (cmd.take_child)
                begin
                    cur_reg <= cand_reg;
                    ofs_reg <= ofs_reg + OFFSET_WIDTH'(1);
                end
                else if (cmd.take_root)
                begin
                    cur_reg <= 10'(root_rd_reg);
                    ofs_reg <= ofs_reg + OFFSET_WIDTH'(1);
                end
                else if (cmd.take_fail)
                begin
                    cur_reg   <= rd_eff.fail;
                    fails_reg <= fails_reg + FW'(1);
                end
                else if (cmd.go_root)
                begin
                    cur_reg <= '0;
                end
            end
        end
    end

    // status
    always_comb
    begin
        stat.op        = req_reg.op;
        stat.last      = req_reg.text_last;
        stat.done      = done_reg;
        stat.cur_root  = cur_reg == '0;
        stat.scan_end  = k_reg >= cnt_reg;
        stat.label_eq  = rd_eff.label == req_reg.text_byte;
        stat.fail_zero = rd_eff.fail == '0;
        stat.fail_cap  = fails_reg >= FailMax;
        stat.term_nz   = rd_eff.term != '0;
    end

    assign res       = res_reg;
    assign res_valid = valid_reg;

endmodule

`default_nettype wire

/* hdl/acfm_controller.sv */
// controller: sequences store loads, child scans and fail walks
`default_nettype none

module acfm_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire acfm_pkg::stat_t stat,
    output acfm_pkg::cmd_t       cmd,
    output logic                 busy
);
    import acfm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DEC   = 11'b00000000010,
        S_CUR   = 11'b00000000100,
        S_RDCH  = 11'b00000001000,
        S_CHK   = 11'b00000010000,
        S_ROOT  = 11'b00000100000,
        S_FAIL  = 11'b00001000000,
        S_FTERM = 11'b00010000000,
        S_FCHK  = 11'b00100000000,
        S_FIN   = 11'b01000000000,
        S_TCHK  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = state_reg != S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.op == OP_START)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.op != OP_TEXT || stat.done)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cur_root)
                begin
                    cmd.rd_root = 1'b1;
                    state_next  = S_ROOT;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.init_scan = 1'b1;
                state_next    = S_RDCH;
            end
            S_RDCH:
            begin
                if (stat.scan_end)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.rd_child   = 1'b1;
                    cmd.next_child = 1'b1;
                    state_next     = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.label_eq)
                begin
                    cmd.take_child = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    state_next = S_RDCH;
                end
            end
            S_ROOT:
            begin
                cmd.take_root = 1'b1;
                state_next    = S_FIN;
            end
            S_FAIL:
            begin
                if (stat.fail_zero || stat.fail_cap)
                begin
                    cmd.go_root = 1'b1;
                    cmd.rd_root = 1'b1;
                    state_next  = S_ROOT;
                end
                else
                begin
                    cmd.take_fail = 1'b1;
                    state_next    = S_FTERM;
                end
            end
            S_FTERM:
            begin
                // read the node the fail link led to
                cmd.rd_cur = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                // terminal fail target reports at once, byte not consumed
                if (stat.term_nz)
                begin
                    cmd.emit_hit = 1'b1;
                    cmd.set_done = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.init_scan = 1'b1;
                    state_next    = S_RDCH;
                end
            end
            S_FIN:
            begin
                // byte consumed; the root is never checked for a term code
                if (stat.cur_root)
                begin
                    if (stat.last)
                    begin
                        cmd.emit_miss = 1'b1;
                        cmd.set_done  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                // entry of the new current node is in the read register
                if (stat.term_nz)
                begin
                    cmd.emit_hit = 1'b1;
                    cmd.set_done = 1'b1;
                end
                else if (stat.last)
                begin
                    cmd.emit_miss = 1'b1;
                    cmd.set_done  = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/aho_corasick_first_match_unit.sv */
// top level of the aho-corasick first match unit
//
// a request is taken when start is high and busy is low; op selects start
// search, node store load, root table load or one text byte. start, loads
// and text bytes after the search ended hold busy for one cycle, so such
// requests cannot be taken back to back. a text byte is first decoded; at
// a non-root node its entry is read, each child label is compared in turn
// (linear scan of the contiguous children) and the list is closed, then
// each fail link is taken, read and checked (a terminal fail target
// reports at once) and its children scanned, until a child matches or
// the walk falls back to the root, where the root table is read. the
// move consumes the byte and a new non-root node gets a term check. the
// node store is a single-port memory with a registered read, so each
// entry is read into a register before it is checked. a result (match or
// not found) shows on result for one cycle with result_valid high, in the
// first cycle after busy falls; the receiver cannot stall it. after a
// result text bytes are ignored until a start search request. reset
// returns to the root with offset zero; stores are undefined until loaded.
`default_nettype none

module aho_corasick_first_match_unit #(
    parameter int NODE_COUNT   = acfm_pkg::NodeCountDefault,
    parameter int OFFSET_WIDTH = acfm_pkg::OffsetWidthDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire acfm_pkg::req_t request,
    output logic                busy,
    output acfm_pkg::res_t      result,
    output logic                result_valid
);
    import acfm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    acfm_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    acfm_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (request),
        .cmd       (cmd),
        .stat      (stat),
        .res       (result),
        .res_valid (result_valid)
    );

endmodule

`default_nettype wire

/* test/tb_aho_corasick_first_match_unit.sv */
// testbench for the aho-corasick first match unit: loads, searches, self-checking
`default_nettype none

module tb_aho_corasick_first_match_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import acfm_pkg::*;

    localparam int ReqBits     = $bits(req_t);
    localparam int LoadedNodes = 64;

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    res_t result;
    logic result_valid;

    aho_corasick_first_match_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .result      (result),
        .result_valid(result_valid)
    );

    // shadow copy of the automaton and search state
    bit [15:0] term_tab  [1024];
    bit [7:0]  depth_tab [1024];
    bit [7:0]  count_tab [1024];
    bit [9:0]  child_tab [1024];
    bit [9:0]  fail_tab  [1024];
    bit [7:0]  label_tab [1024];
    bit [7:0]  root_tab  [256];
    int        cur_node;
    bit [31:0] text_pos;
    bit        search_over;

    res_t pending_matches[$];
    int   errors;
    bit   no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // walk the shadow automaton for one text byte
    function automatic void walk_text(input bit [7:0] c, input bit last,
                                      output bit has, output res_t res);
        int  fails;
        bit  hit;
        bit  got;
        int  id;
        int  nxt;
        fails = 0;
        hit   = 1'b0;
        has   = 1'b0;
        res   = '0;
        if (search_over)
            return;
        while (1)
        begin
            if (cur_node == 0)
            begin
                cur_node = root_tab[c];
                text_pos++;
                break;
            end
            got = 1'b0;
            for (int k = 0; k < count_tab[cur_node]; k++)
            begin
                id = (child_tab[cur_node] + k) & 1023;
                if (!got && label_tab[id] == c)
                begin
                    got = 1'b1;
                    nxt = id;
                end
            end
            if (got)
            begin
                cur_node = nxt;
                text_pos++;
                break;
            end
            nxt = fail_tab[cur_node];
            if (nxt == 0 || fails >= 1024)
            begin
                cur_node = 0;
                continue;
            end
            cur_node = nxt;
            fails++;
            if (term_tab[cur_node] != 0)
            begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit && cur_node != 0 && term_tab[cur_node] != 0)
            hit = 1'b1;
        if (hit)
        begin
            has               = 1'b1;
            res.found         = 1'b1;
            res.first_offset  = text_pos - 32'(depth_tab[cur_node]);
            res.last_offset   = text_pos - 32'd1;
            res.pattern_index = term_tab[cur_node] - 16'd1;
            search_over       = 1'b1;
        end
        else if (last)
        begin
            has               = 1'b1;
            res.found         = 1'b0;
            res.first_offset  = '1;
            res.last_offset   = '1;
            res.pattern_index = '1;
            search_over       = 1'b1;
        end
    endfunction

    // update the shadow state for one accepted request
    task automatic predict(input req_t r);
        bit   has;
        res_t res;
        case (op_t'(r.op))
            OP_START:
            begin
                cur_node    = 0;
                text_pos    = '0;
                search_over = 1'b0;
            end
            OP_NODE:
            begin
                term_tab[r.entry_index]  = r.term_code;
                depth_tab[r.entry_index] = r.node_depth;
                count_tab[r.entry_index] = r.child_count;
                child_tab[r.entry_index] = r.first_child;
                fail_tab[r.entry_index]  = r.fail_node;
                label_tab[r.entry_index] = r.in_label;
            end
            OP_ROOT:
            begin
                if (r.entry_index < 256)
                    root_tab[r.entry_index[7:0]] = r.root_target;
            end
            default:
            begin
                walk_text(r.text_byte, r.text_last, has, res);
                if (has)
                    pending_matches.push_back(res);
            end
        endcase
    endtask

    // send one request, at times with random idle cycles ahead of it
    task automatic send(input req_t r);
        if (!no_idle && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        predict(r);
    endtask

    // check each result against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_matches.size() == 0)
                report("result with nothing expected");
            else
            begin
                res_t e;
                e = pending_matches.pop_front();
                if (result.found !== e.found)
                    report($sformatf("found %0b, expected %0b", result.found, e.found));
                if (result.first_offset !== e.first_offset)
                    report($sformatf("first_offset %0h, expected %0h",
                                     result.first_offset, e.first_offset));
                if (result.last_offset !== e.last_offset)
                    report($sformatf("last_offset %0h, expected %0h",
                                     result.last_offset, e.last_offset));
                if (result.pattern_index !== e.pattern_index)
                    report($sformatf("pattern_index %0h, expected %0h",
                                     result.pattern_index, e.pattern_index));
            end
        end
    end

    // request with random contents in every field
    function automatic req_t rand_req();
        return req_t'(ReqBits'({$urandom, $urandom, $urandom}));
    endfunction

    function automatic req_t node_req(input int id, input int term, input int dep,
                                      input int cnt, input int child, input int fail,
                                      input int label);
        req_t r;
        r             = $urandom_range(0, 1) ? rand_req() : '0;
        r.op          = OP_NODE;
        r.entry_index = 10'(id);
        r.term_code   = 16'(term);
        r.node_depth  = 8'(dep);
        r.child_count = 8'(cnt);
        r.first_child = 10'(child);
        r.fail_node   = 10'(fail);
        r.in_label    = 8'(label);
        return r;
    endfunction

    // random node with a fail link pointing to a lower id, so walks end;
    // children stay in the loaded ids or wrap from the top id through the root
    function automatic req_t rand_node(input int id);
        int term;
        int cnt;
        int label;
        int child;
        term  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 65535) : 0;
        cnt   = ($urandom_range(0, 99) < 3) ? $urandom_range(4, LoadedNodes - 1)
                                            : $urandom_range(0, 3);
        label = ($urandom_range(0, 99) < 85) ? $urandom_range(8'h61, 8'h63)
                                             : $urandom_range(0, 255);
        child = ($urandom_range(0, 99) < 90) ? $urandom_range(1, LoadedNodes - cnt) : 1023;
        return node_req(id, term, $urandom_range(0, 255), cnt, child,
                        (id == 0) ? 0 : $urandom_range(0, id - 1), label);
    endfunction

    function automatic req_t root_req(input int idx, input int target);
        req_t r;
        r             = rand_req();
        r.op          = OP_ROOT;
        r.entry_index = 10'(idx);
        r.root_target = 8'(target);
        return r;
    endfunction

    function automatic req_t text_req(input int c, input bit last);
        req_t r;
        r           = rand_req();
        r.op        = OP_TEXT;
        r.text_byte = 8'(c);
        r.text_last = last;
        return r;
    endfunction

    task automatic send_start();
        req_t r;
        r    = rand_req();
        r.op = OP_START;
        send(r);
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send(text_req(s[i], last_at_end && i == s.len() - 1));
    endtask

    // fill node ids 0 to 63 and the whole root table; node 1023 is loaded by test_directed
    task automatic test_fill_stores();
        for (int i = 0; i < LoadedNodes; i++)
            send(rand_node(i));
        for (int i = 0; i < 256; i++)
            send(root_req(i, 0));
    endtask

    // small hand-built automaton for the named corner cases
    task automatic test_directed();
        // root with a term code that must never report
        send(node_req(0, 5, 0, 0, 0, 0, 8'h72));
        // "a" -> children "ab" (term) and "ac"
        send(node_req(1, 0, 1, 2, 2, 0, "a"));
        send(node_req(2, 1, 2, 0, 0, 0, "b"));
        send(node_req(3, 0, 2, 0, 0, 4, "c"));
        // "c" terminal, reached through the fail link of "ac"
        send(node_req(4, 65535, 1, 0, 0, 0, "c"));
        // child range wrapping past the top id into the root
        send(node_req(5, 0, 1, 2, 1023, 0, "w"));
        send(node_req(1023, 0, 2, 0, 0, 0, "q"));
        // two nonterminal nodes whose fail links form a loop
        send(node_req(6, 0, 1, 0, 0, 7, "x"));
        send(node_req(7, 0, 1, 0, 0, 6, "y"));
        send(root_req("a", 1));
        send(root_req("c", 4));
        send(root_req("w", 5));
        send(root_req("x", 6));
        send(root_req(1023, 9));
        send_start();
        send_text("zab", 1'b1);
        send_text("ab", 1'b1);
        send_start();
        send_text("acz", 1'b0);
        send_start();
        send_text("wrz", 1'b1);
        send_start();
        send_text("xz", 1'b1);
        send_start();
        send(text_req(8'hff, 1'b1));
    endtask

    // reload part of the automaton, then run many short searches with occasional node reloads
    task automatic test_random_searches(input int rounds, input int bytes_per_round);
        int sent;
        int len;
        for (int n = 0; n < rounds; n++)
        begin
            for (int i = 0; i < 10; i++)
                send(rand_node($urandom_range(1, LoadedNodes - 1)));
            for (int i = 0; i < 6; i++)
                send(root_req($urandom_range(0, 99) < 90 ? $urandom_range(0, 255)
                                                         : $urandom_range(256, 1023),
                              $urandom_range(0, 99) < 80 ? $urandom_range(1, LoadedNodes - 1)
                                                         : 0));
            sent = 0;
            while (sent < bytes_per_round)
            begin
                send_start();
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        send(rand_node($urandom_range(1, LoadedNodes - 1)));
                    send(text_req($urandom_range(0, 99) < 85 ? $urandom_range(8'h61, 8'h63)
                                                             : $urandom_range(0, 255),
                                  i == len - 1 || $urandom_range(0, 99) < 2));
                    sent++;
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        errors      = 0;
        no_idle     = 1'b0;
        cur_node    = 0;
        text_pos    = '0;
        search_over = 1'b0;
        rst_n       = 1'b0;
        start       <= 1'b0;
        request     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores();
        test_directed();
        test_random_searches(2, 60);
        no_idle = 1'b1;
        test_random_searches(1, 60);
        no_idle = 1'b0;
        start <= 1'b0;
        while (pending_matches.size() != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hdl/acfm_pkg.sv
hdl/acfm_datapath.sv
hdl/acfm_controller.sv
hdl/aho_corasick_first_match_unit.sv
test/tb_aho_corasick_first_match_unit.sv
